// ===== sv/rtp_pkg.sv =====
`default_nettype none

package rtp_pkg;

	// result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_DIGIT = 3'd1;
	localparam logic [2:0] ST_TOO_BIG  = 3'd2;
	localparam logic [2:0] ST_LINE_END = 3'd3;
	localparam logic [2:0] ST_END      = 3'd4;

	// parse modes
	localparam logic [1:0] MODE_U64 = 2'd0;
	localparam logic [1:0] MODE_U32 = 2'd1;
	localparam logic [1:0] MODE_S64 = 2'd2;
	localparam logic [1:0] MODE_S32 = 2'd3;

	// configuration register indexes
	localparam logic REG_RADIX = 1'b0;
	localparam logic REG_MODE  = 1'b1;

	localparam logic [5:0] RADIX_RESET = 6'd10;
	localparam logic [5:0] RADIX_MIN   = 6'd2;
	localparam logic [5:0] RADIX_MAX   = 6'd36;
	localparam logic [5:0] RADIX_DEC   = 6'd10;

	// range limits
	localparam logic [63:0] LIM_U64     = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] LIM_U32     = 64'h0000_0000_FFFF_FFFF;
	localparam logic [63:0] LIM_S64_POS = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] LIM_S64_NEG = 64'h8000_0000_0000_0000;
	localparam logic [63:0] LIM_S32_POS = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] LIM_S32_NEG = 64'h0000_0000_8000_0000;

	// one input beat
	typedef struct packed {
		logic [7:0] char_code;
		logic       at_end;
		logic       new_parse;
	} rtp_item_t;

	// one result
	typedef struct packed {
		logic [63:0] value;
		logic [2:0]  status;
		logic [7:0]  stop_char;
		logic        stop_is_end;
	} rtp_result_t;

	// configuration seen by the parser
	typedef struct packed {
		logic [5:0] radix;
		logic [1:0] parse_mode;
	} rtp_cfg_t;

endpackage

`default_nettype wire

// ===== sv/rtp_in_reg.sv =====
`default_nettype none

module rtp_in_reg
	import rtp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire rtp_item_t in_item,
	input  wire logic      advance,
	output logic           item_valid_s1,
	output rtp_item_t      item_s1
);

	// slot is free when empty or when its beat moves on this cycle
	assign in_ready = !item_valid_s1 || advance;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			item_valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

// ===== sv/rtp_core.sv =====
`default_nettype none

module rtp_core
	import rtp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire rtp_cfg_t  cfg,
	input  wire logic      fire,
	input  wire rtp_item_t item,
	output logic           res_valid,
	output rtp_result_t    res
);

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_SIGN   = 2'd1;
	localparam logic [1:0] PH_FIRST  = 2'd2;
	localparam logic [1:0] PH_DIGITS = 2'd3;

	logic [1:0]  phase_q, phase_d;
	logic [63:0] acc_q, acc_d;
	logic        neg_q, neg_d;
	logic        ovf_q, ovf_d;

	logic [1:0]  ph_e;
	logic [63:0] acc_e;
	logic        neg_e;
	logic        ovf_e;

	logic [5:0]  base;
	logic [5:0]  dig;
	logic        dig_ok;
	logic        blank;
	logic        line_end;
	logic [69:0] prod;
	logic [70:0] sum;
	logic        step_ovf;
	logic        neg_fin;
	logic [63:0] lim;
	logic        too_big;
	logic [63:0] fin_value;
	logic [7:0]  c;

	assign c = item.char_code;

	// effective base
	always_comb begin
		if (cfg.parse_mode[1]) begin
			base = RADIX_DEC;
		end else if (cfg.radix < RADIX_MIN) begin
			base = RADIX_MIN;
		end else if (cfg.radix > RADIX_MAX) begin
			base = RADIX_MAX;
		end else begin
			base = cfg.radix;
		end
	end

	// digit decode
	always_comb begin
		dig    = 6'd0;
		dig_ok = 1'b0;
		if (c >= "0" && c <= "9") begin
			dig    = 6'(c - "0");
			dig_ok = 1'b1;
		end else if (c >= "a" && c <= "z") begin
			dig    = 6'(c - "a") + 6'd10;
			dig_ok = 1'b1;
		end else if (c >= "A" && c <= "Z") begin
			dig    = 6'(c - "A") + 6'd10;
			dig_ok = 1'b1;
		end
		if (dig >= base) begin
			dig_ok = 1'b0;
		end
	end

	assign blank    = (c == 8'h20) || (c == 8'h09) || (c == 8'hA0);
	assign line_end = (c >= 8'h0A) && (c <= 8'h0D);

	// state as seen by this beat, after a possible restart
	always_comb begin
		if (item.new_parse) begin
			ph_e  = cfg.parse_mode[1] ? PH_SIGN : PH_FIRST;
			acc_e = 64'd0;
			neg_e = 1'b0;
			ovf_e = 1'b0;
		end else begin
			ph_e  = phase_q;
			acc_e = acc_q;
			neg_e = neg_q;
			ovf_e = ovf_q;
		end
	end

	// multiply-accumulate with carry-out as overflow
	assign prod     = {6'd0, acc_e} * {64'd0, base};
	assign sum      = {1'b0, prod} + {65'd0, dig};
	assign step_ovf = |sum[70:64];

	// range check at the end of the number
	assign neg_fin = neg_e && cfg.parse_mode[1];
	always_comb begin
		case (cfg.parse_mode)
			MODE_U64: lim = LIM_U64;
			MODE_U32: lim = LIM_U32;
			MODE_S64: lim = neg_fin ? LIM_S64_NEG : LIM_S64_POS;
			default:  lim = neg_fin ? LIM_S32_NEG : LIM_S32_POS;
		endcase
	end
	assign too_big   = ovf_e || (acc_e > lim);
	assign fin_value = neg_fin ? (64'd0 - acc_e) : acc_e;

	// next state and result
	always_comb begin
		phase_d         = ph_e;
		acc_d           = acc_e;
		neg_d           = neg_e;
		ovf_d           = ovf_e;
		res_valid       = 1'b0;
		res.value       = 64'd0;
		res.status      = ST_OK;
		res.stop_char   = item.at_end ? 8'd0 : c;
		res.stop_is_end = item.at_end;
		case (ph_e)
			PH_SIGN: begin
				if (item.at_end) begin
					res_valid  = 1'b1;
					res.status = ST_END;
				end else if (blank) begin
					phase_d = PH_SIGN;
				end else if (line_end) begin
					res_valid  = 1'b1;
					res.status = ST_LINE_END;
				end else if (c == "+") begin
					phase_d = PH_FIRST;
				end else if (c == "-") begin
					neg_d   = 1'b1;
					phase_d = PH_FIRST;
				end else if (dig_ok) begin
					acc_d   = {58'd0, dig};
					phase_d = PH_DIGITS;
				end else begin
					res_valid  = 1'b1;
					res.status = ST_NO_DIGIT;
				end
			end
			PH_FIRST: begin
				if (item.at_end) begin
					res_valid  = 1'b1;
					res.status = ST_NO_DIGIT;
				end else if (blank) begin
					phase_d = PH_FIRST;
				end else if (dig_ok) begin
					acc_d   = {58'd0, dig};
					phase_d = PH_DIGITS;
				end else begin
					res_valid  = 1'b1;
					res.status = ST_NO_DIGIT;
				end
			end
			PH_DIGITS: begin
				if (item.at_end || !dig_ok) begin
					res_valid = 1'b1;
					if (too_big) begin
						res.status = ST_TOO_BIG;
					end else begin
						res.value = fin_value;
					end
				end else if (!ovf_e) begin
					if (step_ovf) begin
						ovf_d = 1'b1;
					end else begin
						acc_d = sum[63:0];
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
		if (res_valid) begin
			phase_d = PH_IDLE;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= 64'd0;
			neg_q   <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			ovf_q   <= ovf_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/rtp_out_reg.sv =====
`default_nettype none

module rtp_out_reg
	import rtp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire logic        res_valid,
	input  wire rtp_result_t res,
	input  wire logic        out_ready,
	output logic             out_valid_q,
	output rtp_result_t      out_q,
	output logic             advance
);

	// register moves when empty or drained this cycle
	assign advance = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= load && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load && res_valid) begin
			out_q <= res;
		end
	end

endmodule

`default_nettype wire

// ===== sv/radix_integer_text_parser.sv =====
// channel   dir  signals                 content
// s_axis    in   tvalid tready tdata     tdata: char_code[7:0]
//                tuser                   tuser: at_end[0] new_parse[1]
// m_axis    out  tvalid tready tdata     tdata: value[63:0] stop_char[71:64]
//                tuser                   tuser: status[2:0] stop_is_end[3]
// cfg       in   cfg_we cfg_index cfg_wdata  0 radix, 1 parse_mode
//
// one beat per cycle sustained while the output is not stalled; a beat is held in the input register
// and its result, where it yields one, is registered in the output register.
// the multiply-add on the 64-bit accumulator is combinational, between the two registers.
// arst_n clears valid flags, parser state and config (radix 10, mode 0).
// a stalled output holds the pipe; input keeps taking beats until the input slot is full.
`default_nettype none

module radix_integer_text_parser
	import rtp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // char_code
	input  wire logic [1:0]  s_tuser,   // at_end, new_parse
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,   // value, stop_char
	output logic [3:0]       m_tuser,   // status, stop_is_end
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [5:0]  cfg_wdata
);

	rtp_cfg_t    cfg_q;
	rtp_item_t   in_item;
	rtp_item_t   item_s1;
	logic        item_valid_s1;
	logic        advance;
	logic        fire;
	logic        res_valid;
	rtp_result_t res;
	rtp_result_t out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radix      <= RADIX_RESET;
			cfg_q.parse_mode <= MODE_U64;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RADIX: cfg_q.radix      <= cfg_wdata;
				REG_MODE:  cfg_q.parse_mode <= cfg_wdata[1:0];
				default:   cfg_q.radix      <= cfg_q.radix;
			endcase
		end
	end

	assign in_item.char_code = s_tdata;
	assign in_item.at_end    = s_tuser[0];
	assign in_item.new_parse = s_tuser[1];

	rtp_in_reg u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_item       (in_item),
		.advance       (advance),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1)
	);

	assign fire = item_valid_s1 && advance;

	rtp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.fire      (fire),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	rtp_out_reg u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (item_valid_s1),
		.res_valid   (res_valid),
		.res         (res),
		.out_ready   (m_tready),
		.out_valid_q (m_tvalid),
		.out_q       (out_q),
		.advance     (advance)
	);

	assign m_tdata = {out_q.stop_char, out_q.value};
	assign m_tuser = {out_q.stop_is_end, out_q.status};

	// error results carry zero value
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (out_q.status != ST_OK) |-> out_q.value == 64'd0)
		else $error("nonzero value on error result");

	// end of input reports no stop character
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_q.stop_is_end |-> out_q.stop_char == 8'd0)
		else $error("stop char set at end of input");

	// a beat in the input slot holds while the output is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid_s1 && !advance |=> item_valid_s1 && $stable(item_s1))
		else $error("input slot lost a beat during stall");

	// status stays within the defined codes
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> out_q.status <= ST_END)
		else $error("undefined status code");

endmodule

`default_nettype wire
